>>> rtl/gvm_pkg.sv
// ----------------------------------------------------------------------------
// Gamma-to-velocity map package
// Shared types, codes and sizing constants for the semblance map unit.
// ----------------------------------------------------------------------------
package gvm_pkg;

  // default sizes
  localparam int DEPTH_SAMPLES_DEF   = 256;
  localparam int GAMMA_VALUES_DEF    = 32;
  localparam int VELOCITY_VALUES_DEF = 64;
  localparam int GRID_DEPTHS_DEF     = 256;

  // shared divider widths: dividend/quotient and divisor/remainder
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 36;

  // shared multiplier operand width
  localparam int MUL_W = 32;

  // request kinds
  typedef enum logic [1:0] {
    MODE_LOAD_VEL  = 2'd0,
    MODE_LOAD_SEMB = 2'd1,
    MODE_PREPARE   = 2'd2,
    MODE_QUERY     = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FIRST_DEPTH      = 3'd0,
    REG_DEPTH_STEP       = 3'd1,
    REG_GRID_FIRST_DEPTH = 3'd2,
    REG_GRID_DEPTH_STEP  = 3'd3,
    REG_FIRST_GAMMA      = 3'd4,
    REG_GAMMA_STEP       = 3'd5,
    REG_FIRST_VELOCITY   = 3'd6,
    REG_VELOCITY_STEP    = 3'd7
  } reg_index_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/gvm_div.sv
// ----------------------------------------------------------------------------
// Gamma-to-velocity map divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gvm_div import gvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output div_stat_t         stat,
  output logic [DIV_NW-1:0] quot,
  output logic [DIV_DW-1:0] rem
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dvs;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW:0]   diff;
  logic              fits;

  // trial subtract
  assign sh   = {rem_r, quo[DIV_NW-1]};
  assign diff = sh - {1'b0, dvs};
  assign fits = (sh >= {1'b0, dvs});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(DIV_NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem_r <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      quo   <= {quo[DIV_NW-2:0], fits};
      rem_r <= fits ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = quo;
  assign rem       = rem_r;

endmodule

>>> rtl/gvm_mul.sv
// ----------------------------------------------------------------------------
// Gamma-to-velocity map multiplier
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module gvm_mul import gvm_pkg::*; (
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [2*MUL_W-1:0] p
);

  // product register
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/gamma_to_velocity_spectrum_map_unit.sv
// ----------------------------------------------------------------------------
// Gamma-to-velocity spectrum map unit
// Holds an interval-velocity column and a gamma semblance panel, prepares
// per-depth average-velocity terms and answers semblance at a velocity.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tuser mode, s_tdata fields
//   m_*       out  m_tvalid/m_tready  m_tdata result fields
//   wr_*      in   wr_en              wr_index, wr_data
//
// A prepare runs on the shared divider: up to three divides per output
// depth and one per grid depth after the first.
// The input is ready only while the sequencer is idle; a finished result
// waits in the output register while the next request is taken.
// Synchronous reset clears the prepared flag and sets configuration defaults.
// ----------------------------------------------------------------------------
module gamma_to_velocity_spectrum_map_unit import gvm_pkg::*; #(
  parameter int DEPTH_SAMPLES   = DEPTH_SAMPLES_DEF,
  parameter int GAMMA_VALUES    = GAMMA_VALUES_DEF,
  parameter int VELOCITY_VALUES = VELOCITY_VALUES_DEF,
  parameter int GRID_DEPTHS     = GRID_DEPTHS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] depth_index, [12:8] gamma_index, [18:13] velocity_index,
  // [38:19] interval_velocity, [54:39] semblance, [55] zero
  input  logic [55:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] velocity_semblance, [16] inside_range, [17] prepared, [23:18] zero
  output logic [23:0] m_tdata,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [19:0] wr_data
);

  localparam int GAW  = (GRID_DEPTHS > 1) ? $clog2(GRID_DEPTHS) : 1;
  localparam int DAW  = $clog2(DEPTH_SAMPLES);
  localparam int GMW  = $clog2(GAMMA_VALUES);
  localparam int PAW  = $clog2(GAMMA_VALUES * DEPTH_SAMPLES);
  localparam int MAXN = (GRID_DEPTHS > DEPTH_SAMPLES) ? GRID_DEPTHS : DEPTH_SAMPLES;
  localparam int SW   = $clog2(MAXN + 1);

  typedef enum logic [25:0] {
    ST_IDLE  = 26'h0000001,
    ST_FIN   = 26'h0000002,
    ST_Q0    = 26'h0000004,
    ST_Q1    = 26'h0000008,
    ST_Q2    = 26'h0000010,
    ST_Q3    = 26'h0000020,
    ST_Q4    = 26'h0000040,
    ST_Q5    = 26'h0000080,
    ST_A_RD  = 26'h0000100,
    ST_A_MUL = 26'h0000200,
    ST_A_ACC = 26'h0000400,
    ST_A_DEN = 26'h0000800,
    ST_A_DIV = 26'h0001000,
    ST_B_MUL = 26'h0002000,
    ST_B_D   = 26'h0004000,
    ST_B_QDV = 26'h0008000,
    ST_B_VR1 = 26'h0010000,
    ST_B_RA1 = 26'h0020000,
    ST_B_RA2 = 26'h0040000,
    ST_B_I1  = 26'h0080000,
    ST_B_I2  = 26'h0100000,
    ST_B_IDV = 26'h0200000,
    ST_B_OFF = 26'h0400000,
    ST_B_PRD = 26'h0800000,
    ST_B_INV = 26'h1000000,
    ST_B_RDV = 26'h2000000
  } state_t;

  // configuration registers
  logic [19:0] first_depth, depth_step, grid_first_depth, grid_depth_step;
  logic [15:0] first_gamma, gamma_step;
  logic [19:0] first_velocity, velocity_step;

  // request fields
  mode_t       in_mode;
  logic [7:0]  in_depth;
  logic [4:0]  in_gamma;
  logic [5:0]  in_vidx;
  logic [19:0] in_ivel;
  logic [15:0] in_semb;
  logic        accept;

  assign in_mode  = mode_t'(s_tuser[1:0]);
  assign in_depth = s_tdata[7:0];
  assign in_gamma = s_tdata[12:8];
  assign in_vidx  = s_tdata[18:13];
  assign in_ivel  = s_tdata[38:19];
  assign in_semb  = s_tdata[54:39];
  assign accept   = s_tvalid && s_tready;

  // sequencer state
  state_t      state;
  logic        flag;
  logic [SW-1:0] step_idx;
  logic [7:0]  z_reg;
  logic [5:0]  iv_reg;
  logic [15:0] res_sem;
  logic        res_in;
  logic [55:0] acc;
  logic [40:0] acc2;
  logic [19:0] r_reg;
  logic [GAW-1:0] q_reg;
  logic [19:0] a0_reg, a1_reg, vr;
  logic [GMW-1:0] gidx;
  logic [15:0] f_reg, s0_reg;
  logic        neg_reg;

  // memories
  logic [19:0] vcol_mem [GRID_DEPTHS];
  logic [19:0] avg_mem  [GRID_DEPTHS];
  logic [15:0] pan_mem  [GAMMA_VALUES * DEPTH_SAMPLES];
  logic [23:0] off_mem  [DEPTH_SAMPLES];
  logic [31:0] inv_mem  [DEPTH_SAMPLES];
  logic [19:0] vcol_q, avg_q;
  logic [15:0] pan_q;
  logic [23:0] off_q;
  logic [31:0] inv_q;

  logic           vcol_we;
  logic [GAW-1:0] vcol_raddr;
  logic           avg_we;
  logic [GAW-1:0] avg_waddr, avg_raddr;
  logic [19:0]    avg_wdata;
  logic           pan_we;
  logic [PAW-1:0] pan_waddr, pan_raddr;
  logic           off_we, inv_we;
  logic [31:0]    inv_wdata;
  logic [DAW-1:0] dep_waddr, dep_raddr;

  // shared units
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic               div_start;
  logic [DIV_NW-1:0]  div_dividend, div_quot;
  logic [DIV_DW-1:0]  div_divisor, div_rem;
  div_stat_t          div_st;

  gvm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  gvm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .stat(div_st), .quot(div_quot), .rem(div_rem)
  );

  // derived values
  logic [19:0] gds_eff;
  logic [15:0] gs_eff;
  logic [33:0] d_raw;
  logic [27:0] diff_raw;
  logic [35:0] den;
  logic [35:0] prod;
  logic [36:0] off_sum;
  logic [22:0] pos_idx;
  logic [15:0] pos_frac;
  logic [32:0] interp;
  logic        a_last, b_last, q_ok, ld_vel_ok, ld_sem_ok;

  assign gds_eff  = (grid_depth_step == 20'd0) ? 20'd1 : grid_depth_step;
  assign gs_eff   = (gamma_step == 16'd0) ? 16'd1 : gamma_step;
  assign d_raw    = 34'(first_depth) + 34'(mul_p[31:0]) - 34'(grid_first_depth);
  assign diff_raw = 28'(first_velocity) + 28'(mul_p[25:0]) - 28'(off_q);
  assign den      = 36'(grid_first_depth) + 36'(mul_p[31:0]);
  assign prod     = mul_p[35:0];
  assign off_sum  = 37'(mul_p[35:0]) + 37'd2048;
  assign pos_idx  = mul_p[58:36];
  assign pos_frac = mul_p[35:20];
  assign interp   = neg_reg ? ({1'b0, s0_reg, 16'd0} + 33'd32768 - 33'(mul_p[31:0]))
                            : ({1'b0, s0_reg, 16'd0} + 33'd32768 + 33'(mul_p[31:0]));
  assign a_last   = (step_idx == SW'(GRID_DEPTHS - 1));
  assign b_last   = (step_idx == SW'(DEPTH_SAMPLES - 1));
  assign q_ok     = flag && (32'(in_depth) < 32'(DEPTH_SAMPLES))
                    && (32'(in_vidx) < 32'(VELOCITY_VALUES));
  assign ld_vel_ok = (32'(in_depth) < 32'(GRID_DEPTHS));
  assign ld_sem_ok = (32'(in_gamma) < 32'(GAMMA_VALUES))
                    && (32'(in_depth) < 32'(DEPTH_SAMPLES));

  assign s_tready = (state == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_depth      <= 20'd0;
      depth_step       <= 20'd16;
      grid_first_depth <= 20'd0;
      grid_depth_step  <= 20'd16;
      first_gamma      <= 16'd2048;
      gamma_step       <= 16'd41;
      first_velocity   <= 20'd24000;
      velocity_step    <= 20'd800;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_FIRST_DEPTH:      first_depth      <= wr_data;
        REG_DEPTH_STEP:       depth_step       <= wr_data;
        REG_GRID_FIRST_DEPTH: grid_first_depth <= wr_data;
        REG_GRID_DEPTH_STEP:  grid_depth_step  <= wr_data;
        REG_FIRST_GAMMA:      first_gamma      <= wr_data[15:0];
        REG_GAMMA_STEP:       gamma_step       <= wr_data[15:0];
        REG_FIRST_VELOCITY:   first_velocity   <= wr_data;
        REG_VELOCITY_STEP:    velocity_step    <= wr_data;
        default: ;
      endcase
    end
  end

  // operand, address and write-enable selection
  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = 36'd1;
    vcol_we      = accept && (in_mode == MODE_LOAD_VEL) && ld_vel_ok;
    pan_we       = accept && (in_mode == MODE_LOAD_SEMB) && ld_sem_ok;
    pan_waddr    = PAW'(in_gamma) * PAW'(DEPTH_SAMPLES) + PAW'(in_depth);
    pan_raddr    = PAW'(gidx) * PAW'(DEPTH_SAMPLES) + PAW'(z_reg);
    vcol_raddr   = step_idx[GAW-1:0];
    avg_we       = 1'b0;
    avg_waddr    = step_idx[GAW-1:0];
    avg_wdata    = div_quot[19:0];
    avg_raddr    = q_reg;
    off_we       = 1'b0;
    inv_we       = 1'b0;
    inv_wdata    = 32'hFFFF_FFFF;
    dep_waddr    = step_idx[DAW-1:0];
    dep_raddr    = DAW'(z_reg);
    unique case (state)
      ST_Q0: begin
        mul_a = 32'(iv_reg);
        mul_b = 32'(velocity_step);
      end
      ST_Q1: begin
        mul_a = 32'(diff_raw[26:0]);
        mul_b = inv_q;
      end
      ST_Q2: begin
        pan_raddr = PAW'(pos_idx[GMW-1:0]) * PAW'(DEPTH_SAMPLES) + PAW'(z_reg);
      end
      ST_Q3: begin
        pan_raddr = (PAW'(gidx) + PAW'(1)) * PAW'(DEPTH_SAMPLES) + PAW'(z_reg);
      end
      ST_Q4: begin
        mul_a = (pan_q < s0_reg) ? 32'(s0_reg - pan_q) : 32'(pan_q - s0_reg);
        mul_b = 32'(f_reg);
      end
      ST_A_MUL: begin
        mul_a = 32'(vcol_q);
        mul_b = (step_idx == '0) ? 32'(grid_first_depth) : 32'(gds_eff);
        if (step_idx == '0) begin
          avg_we    = 1'b1;
          avg_wdata = vcol_q;
        end
      end
      ST_A_ACC: begin
        mul_a = 32'(step_idx);
        mul_b = 32'(gds_eff);
      end
      ST_A_DEN: begin
        div_start    = 1'b1;
        div_dividend = acc + 56'(den >> 1);
        div_divisor  = den;
      end
      ST_A_DIV: begin
        avg_we = div_st.done;
      end
      ST_B_MUL: begin
        mul_a = 32'(step_idx);
        mul_b = 32'(depth_step);
      end
      ST_B_D: begin
        avg_raddr = '0;
        if (!d_raw[33]) begin
          div_start    = 1'b1;
          div_dividend = 56'(d_raw[32:0]);
          div_divisor  = 36'(gds_eff);
        end
      end
      ST_B_QDV: begin
        if (div_quot >= 56'(GRID_DEPTHS - 1)) begin
          avg_raddr = GAW'(GRID_DEPTHS - 1);
        end else begin
          avg_raddr = div_quot[GAW-1:0];
        end
      end
      ST_B_RA1: begin
        avg_raddr = q_reg + GAW'(1);
      end
      ST_B_RA2: begin
        mul_a = 32'(a0_reg);
        mul_b = 32'(gds_eff - r_reg);
      end
      ST_B_I1: begin
        mul_a = 32'(a1_reg);
        mul_b = 32'(r_reg);
      end
      ST_B_I2: begin
        div_start    = 1'b1;
        div_dividend = 56'(acc2) + 56'(mul_p[39:0]) + 56'(gds_eff >> 1);
        div_divisor  = 36'(gds_eff);
      end
      ST_B_OFF: begin
        mul_a = 32'(first_gamma);
        mul_b = 32'(vr);
      end
      ST_B_PRD: begin
        off_we = 1'b1;
        mul_a  = 32'(vr);
        mul_b  = 32'(gs_eff);
      end
      ST_B_INV: begin
        if (prod == 36'd0) begin
          inv_we = 1'b1;
        end else begin
          div_start    = 1'b1;
          div_dividend = (56'd1 << 48) + 56'(prod >> 1);
          div_divisor  = prod;
        end
      end
      ST_B_RDV: begin
        inv_we    = div_st.done;
        inv_wdata = (|div_quot[55:32]) ? 32'hFFFF_FFFF : div_quot[31:0];
      end
      default: ;
    endcase
  end

  // storage
  always_ff @(posedge clk) begin
    if (vcol_we) vcol_mem[GAW'(in_depth)] <= in_ivel;
    vcol_q <= vcol_mem[vcol_raddr];
  end

  always_ff @(posedge clk) begin
    if (avg_we) avg_mem[avg_waddr] <= avg_wdata;
    avg_q <= avg_mem[avg_raddr];
  end

  always_ff @(posedge clk) begin
    if (pan_we) pan_mem[pan_waddr] <= in_semb;
    pan_q <= pan_mem[pan_raddr];
  end

  always_ff @(posedge clk) begin
    if (off_we) off_mem[dep_waddr] <= off_sum[35:12];
    off_q <= off_mem[dep_raddr];
  end

  always_ff @(posedge clk) begin
    if (inv_we) inv_mem[dep_waddr] <= inv_wdata;
    inv_q <= inv_mem[dep_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      flag     <= 1'b0;
      step_idx <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            z_reg   <= in_depth;
            iv_reg  <= in_vidx;
            res_sem <= 16'd0;
            res_in  <= 1'b0;
            unique case (in_mode)
              MODE_LOAD_VEL: begin
                if (ld_vel_ok) flag <= 1'b0;
                state <= ST_FIN;
              end
              MODE_LOAD_SEMB: begin
                if (ld_sem_ok) flag <= 1'b0;
                state <= ST_FIN;
              end
              MODE_PREPARE: begin
                step_idx <= '0;
                state    <= ST_A_RD;
              end
              MODE_QUERY: begin
                state <= q_ok ? ST_Q0 : ST_FIN;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        // query
        ST_Q0: state <= ST_Q1;
        ST_Q1: state <= diff_raw[27] ? ST_FIN : ST_Q2;
        ST_Q2: begin
          gidx  <= pos_idx[GMW-1:0];
          f_reg <= pos_frac;
          state <= (pos_idx >= 23'(GAMMA_VALUES - 1)) ? ST_FIN : ST_Q3;
        end
        ST_Q3: begin
          s0_reg <= pan_q;
          state  <= ST_Q4;
        end
        ST_Q4: begin
          neg_reg <= (pan_q < s0_reg);
          state   <= ST_Q5;
        end
        ST_Q5: begin
          res_sem <= interp[31:16];
          res_in  <= 1'b1;
          state   <= ST_FIN;
        end
        // running average over the grid
        ST_A_RD:  state <= ST_A_MUL;
        ST_A_MUL: state <= ST_A_ACC;
        ST_A_ACC: begin
          if (step_idx == '0) begin
            acc <= 56'(mul_p[39:0]);
            if (a_last) begin
              step_idx <= '0;
              state    <= ST_B_MUL;
            end else begin
              step_idx <= step_idx + SW'(1);
              state    <= ST_A_RD;
            end
          end else begin
            acc   <= acc + 56'(mul_p[39:0]);
            state <= ST_A_DEN;
          end
        end
        ST_A_DEN: state <= ST_A_DIV;
        ST_A_DIV: begin
          if (div_st.done) begin
            if (a_last) begin
              step_idx <= '0;
              state    <= ST_B_MUL;
            end else begin
              step_idx <= step_idx + SW'(1);
              state    <= ST_A_RD;
            end
          end
        end
        // resample per output depth
        ST_B_MUL: state <= ST_B_D;
        ST_B_D:   state <= d_raw[33] ? ST_B_VR1 : ST_B_QDV;
        ST_B_QDV: begin
          if (div_st.done) begin
            r_reg <= div_rem[19:0];
            q_reg <= div_quot[GAW-1:0];
            state <= (div_quot >= 56'(GRID_DEPTHS - 1)) ? ST_B_VR1 : ST_B_RA1;
          end
        end
        ST_B_VR1: begin
          vr    <= avg_q;
          state <= ST_B_OFF;
        end
        ST_B_RA1: begin
          a0_reg <= avg_q;
          state  <= ST_B_RA2;
        end
        ST_B_RA2: begin
          a1_reg <= avg_q;
          state  <= ST_B_I1;
        end
        ST_B_I1: begin
          acc2  <= mul_p[40:0];
          state <= ST_B_I2;
        end
        ST_B_I2: state <= ST_B_IDV;
        ST_B_IDV: begin
          if (div_st.done) begin
            vr    <= div_quot[19:0];
            state <= ST_B_OFF;
          end
        end
        ST_B_OFF: state <= ST_B_PRD;
        ST_B_PRD: state <= ST_B_INV;
        ST_B_INV: begin
          if (prod == 36'd0) begin
            if (b_last) begin
              flag  <= 1'b1;
              state <= ST_FIN;
            end else begin
              step_idx <= step_idx + SW'(1);
              state    <= ST_B_MUL;
            end
          end else begin
            state <= ST_B_RDV;
          end
        end
        ST_B_RDV: begin
          if (div_st.done) begin
            if (b_last) begin
              flag  <= 1'b1;
              state <= ST_FIN;
            end else begin
              step_idx <= step_idx + SW'(1);
              state    <= ST_B_MUL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {6'd0, flag, res_in, res_sem};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // divider is never restarted while it runs
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // no request is taken while a divide is in flight
  a_ready_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_st.busy)
    else $error("request accepted during divide");

  // a finished prepare leaves the flag set
  a_prep_flag: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_B_RDV || $past(state) == ST_B_INV) && state == ST_FIN
    |-> flag)
    else $error("prepare finished without flag");

  // an inside answer needs a prepared map
  a_inside_prep: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[16]) |-> m_tdata[17])
    else $error("inside result while not prepared");
`endif

endmodule
